// ===== hdl/mbrr_pkg.sv =====
// Shared constants, codes and the CRC-16 byte step for the Modbus RTU
// single register reader. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbrr_pkg;

  // Receive buffer depth: bytes are counted up to this value, then saturate
  localparam int unsigned RX_BUFFER_DEPTH = 16;
  localparam int unsigned RX_CNT_W = $clog2(RX_BUFFER_DEPTH + 1);

  // Input operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Outcome status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CRC_ERR   = 2'd1;
  localparam logic [1:0] ST_BAD_FRAME = 2'd2;

  // Result kinds
  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_OUTCOME = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] REG_REG_ADDR   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT    = 2'd2;
  localparam logic [1:0] REG_GAP        = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Protocol constants
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  REPLY_BYTE_COUNT  = 8'h02;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  REQ_COUNT_HI      = 8'h00;
  localparam logic [7:0]  REQ_COUNT_LO      = 8'h01;
  localparam int unsigned REPLY_LEN         = 7;
  localparam int unsigned CRC_COVER_LEN     = 5;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_SLAVE_ADDR = 8'd1;
  localparam logic [15:0] RST_REG_ADDR   = 16'd4;
  localparam logic [15:0] RST_TIMEOUT    = 16'd200;
  localparam logic [7:0]  RST_GAP        = 8'd4;

  // Handshake between the top level and the request generator
  typedef struct packed {
    logic load;     // start a new request
    logic advance;  // output slot free: a byte may leave this cycle
  } req_ctrl_t;

  typedef struct packed {
    logic       active;  // bytes still to send
    logic [7:0] tx_byte;
    logic       last;
  } req_stat_t;

  // Reflected CRC-16 (Modbus) over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mbrr_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on mbrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mbrr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface mbrr_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         tx_byte;
  logic               last;
  logic [1:0]         status;
  logic signed [15:0] level;
  logic [4:0]         rx_count;
  logic [31:0]        ok_count;
  logic [31:0]        err_count;

  modport source (output valid, output kind, output tx_byte, output last, output status,
                  output level, output rx_count, output ok_count, output err_count,
                  input ready);
  modport sink   (input valid, input kind, input tx_byte, input last, input status,
                  input level, input rx_count, input ok_count, input err_count,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/modbus_rtu_single_register_reader.sv =====
// Top level of the Modbus RTU single holding register reader.
// Depends on mbrr_pkg, mbrr_in_if, mbrr_out_if and mbrr_req_gen.
`timescale 1ns / 1ps
`default_nettype none

// Modbus RTU master for one "read one holding register" transaction. Input
// beats carry a start, a received byte or a one millisecond tick; result
// beats carry either a request byte to transmit (kind 0) or the outcome of
// the transaction (kind 1). A start clears the receive state, arms the reply
// window and streams the 8-byte request, CRC low byte first. Received bytes
// are counted (saturating at the buffer depth), the first seven are stored
// and the CRC over the first five kept. A tick closes the frame when the
// timeout expires or, once data has arrived, when the silence gap is reached;
// the outcome gives ok, crc error or bad frame, the signed register value and
// wrapping ok/error totals. Bytes and ticks while idle are dropped.
// Rate: one input beat per cycle unless held, each taken into an input
// register and resolved from there. A start holds the input while the
// request generator moves its eight bytes through the single output
// register; a tick waits for that register to be free.
// Configuration writes are taken at any time but belong to idle periods.
module modbus_rtu_single_register_reader (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  mbrr_in_if.sink                           in_ch,
  mbrr_out_if.source                        out_ch,
  input  wire logic                         cfg_we_i,
  input  wire logic [mbrr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mbrr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mbrr_pkg::*;

  // Configuration registers
  logic [7:0]  slave_addr_q;
  logic [15:0] reg_addr_q;
  logic [15:0] timeout_q;
  logic [7:0]  gap_q;

  // Input register
  logic       in_valid_q;
  logic [1:0] in_op_q;
  logic [7:0] in_byte_q;

  // Transaction state
  logic                busy_q, busy_d;
  logic [RX_CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]         rcrc_q, rcrc_d;
  logic [15:0]         elapsed_q, elapsed_d;
  logic [7:0]          silence_q, silence_d;
  logic [31:0]         good_q, good_d;
  logic [31:0]         bad_q, bad_d;
  logic [7:0]          frame_q [REPLY_LEN];

  // Output register
  logic               out_valid_q, out_valid_d;
  logic               o_kind_q, o_kind_d;
  logic [7:0]         o_tx_q, o_tx_d;
  logic               o_last_q, o_last_d;
  logic [1:0]         o_status_q, o_status_d;
  logic signed [15:0] o_level_q, o_level_d;
  logic [4:0]         o_rxc_q, o_rxc_d;
  logic [31:0]        o_ok_q, o_ok_d;
  logic [31:0]        o_err_q, o_err_d;

  req_ctrl_t req_ctrl;
  req_stat_t req_stat;

  logic       out_free;
  logic       go;
  logic       in_take;
  logic       store_byte;
  logic       frame_close;
  logic       header_ok;
  logic [1:0] status_c;
  logic [15:0] level_c;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= RST_SLAVE_ADDR;
      reg_addr_q   <= RST_REG_ADDR;
      timeout_q    <= RST_TIMEOUT;
      gap_q        <= RST_GAP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SLAVE_ADDR: slave_addr_q <= cfg_data_i[7:0];
        REG_REG_ADDR:   reg_addr_q   <= cfg_data_i;
        REG_TIMEOUT:    timeout_q    <= cfg_data_i;
        REG_GAP:        gap_q        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control
  // ---------------------------------------------------------------------------
  // The output slot frees up when empty or when its beat leaves this cycle.
  assign out_free = !out_valid_q || out_ch.ready;

  // Resolve the held item once the request stream is done; a tick may emit
  // an outcome, so it also needs the output slot.
  assign go = in_valid_q && !req_stat.active && ((in_op_q != OP_TICK) || out_free);

  assign in_ch.ready = !in_valid_q || go;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q   <= in_ch.operation;
      in_byte_q <= in_ch.rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Request generator
  // ---------------------------------------------------------------------------
  assign req_ctrl.load    = go && (in_op_q == OP_START);
  assign req_ctrl.advance = out_free;

  mbrr_req_gen u_req_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slave_addr_i (slave_addr_q),
    .reg_addr_i   (reg_addr_q),
    .ctrl_i       (req_ctrl),
    .stat_o       (req_stat)
  );

  // ---------------------------------------------------------------------------
  // Frame checks, used by a closing tick
  // ---------------------------------------------------------------------------
  assign header_ok = (cnt_q == RX_CNT_W'(REPLY_LEN)) && (frame_q[0] == slave_addr_q) &&
                     (frame_q[1] == FUNC_READ_HOLDING) && (frame_q[2] == REPLY_BYTE_COUNT);

  always_comb begin
    status_c = ST_BAD_FRAME;
    level_c  = '0;
    if (header_ok) begin
      if ({frame_q[6], frame_q[5]} == rcrc_q) begin
        status_c = ST_OK;
        level_c  = {frame_q[3], frame_q[4]};
      end else begin
        status_c = ST_CRC_ERR;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Transaction update and output register
  // ---------------------------------------------------------------------------
  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    rcrc_d      = rcrc_q;
    elapsed_d   = elapsed_q;
    silence_d   = silence_q;
    good_d      = good_q;
    bad_d       = bad_q;
    store_byte  = 1'b0;
    frame_close = 1'b0;

    out_valid_d = out_valid_q && !out_ch.ready;
    o_kind_d    = o_kind_q;
    o_tx_d      = o_tx_q;
    o_last_d    = o_last_q;
    o_status_d  = o_status_q;
    o_level_d   = o_level_q;
    o_rxc_d     = o_rxc_q;
    o_ok_d      = o_ok_q;
    o_err_d     = o_err_q;

    // Request bytes go straight into the output slot
    if (req_stat.active && out_free) begin
      out_valid_d = 1'b1;
      o_kind_d    = KIND_TX;
      o_tx_d      = req_stat.tx_byte;
      o_last_d    = req_stat.last;
      o_status_d  = ST_OK;
      o_level_d   = '0;
      o_rxc_d     = '0;
      o_ok_d      = '0;
      o_err_d     = '0;
    end

    if (go) begin
      case (in_op_q)
        OP_START: begin
          // drop any open transaction silently and rearm
          busy_d    = 1'b1;
          cnt_d     = '0;
          rcrc_d    = CRC_INIT;
          elapsed_d = '0;
          silence_d = '0;
        end
        OP_BYTE: begin
          if (busy_q) begin
            store_byte = (cnt_q < RX_CNT_W'(REPLY_LEN));
            if (cnt_q < RX_CNT_W'(CRC_COVER_LEN)) begin
              rcrc_d = crc_byte(rcrc_q, in_byte_q);
            end
            if (cnt_q < RX_CNT_W'(RX_BUFFER_DEPTH)) begin
              cnt_d = cnt_q + RX_CNT_W'(1);
            end
            silence_d = '0;
          end
        end
        OP_TICK: begin
          if (busy_q) begin
            if (elapsed_q != 16'hFFFF) begin
              elapsed_d = elapsed_q + 16'd1;
            end
            if (silence_q != 8'hFF) begin
              silence_d = silence_q + 8'd1;
            end
            frame_close = (elapsed_d >= timeout_q) ||
                          ((cnt_q != '0) && (silence_d >= gap_q));
            if (frame_close) begin
              busy_d = 1'b0;
              if (status_c == ST_OK) begin
                good_d = good_q + 32'd1;
              end else begin
                bad_d = bad_q + 32'd1;
              end
              out_valid_d = 1'b1;
              o_kind_d    = KIND_OUTCOME;
              o_tx_d      = '0;
              o_last_d    = 1'b0;
              o_status_d  = status_c;
              o_level_d   = level_c;
              o_rxc_d     = 5'(cnt_q);
              o_ok_d      = good_d;
              o_err_d     = bad_d;
            end
          end
        end
        default: ;  // unused code: drop
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      rcrc_q      <= CRC_INIT;
      elapsed_q   <= '0;
      silence_q   <= '0;
      good_q      <= '0;
      bad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      rcrc_q      <= rcrc_d;
      elapsed_q   <= elapsed_d;
      silence_q   <= silence_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    o_kind_q   <= o_kind_d;
    o_tx_q     <= o_tx_d;
    o_last_q   <= o_last_d;
    o_status_q <= o_status_d;
    o_level_q  <= o_level_d;
    o_rxc_q    <= o_rxc_d;
    o_ok_q     <= o_ok_d;
    o_err_q    <= o_err_d;
    if (store_byte) begin
      frame_q[cnt_q[2:0]] <= in_byte_q;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.kind      = o_kind_q;
  assign out_ch.tx_byte   = o_tx_q;
  assign out_ch.last      = o_last_q;
  assign out_ch.status    = o_status_q;
  assign out_ch.level     = o_level_q;
  assign out_ch.rx_count  = o_rxc_q;
  assign out_ch.ok_count  = o_ok_q;
  assign out_ch.err_count = o_err_q;

endmodule

`default_nettype wire

// ===== hdl/mbrr_req_gen.sv =====
// Request generator: streams the 8-byte read request, CRC built as it goes.
// Depends on mbrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbrr_req_gen (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       slave_addr_i,
  input  wire logic [15:0]      reg_addr_i,
  input  wire mbrr_pkg::req_ctrl_t ctrl_i,
  output mbrr_pkg::req_stat_t   stat_o
);
  import mbrr_pkg::*;

  logic        act_q, act_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  byte_cur;
  logic        push;

  always_comb begin
    case (idx_q)
      3'd0:    byte_cur = slave_addr_i;
      3'd1:    byte_cur = FUNC_READ_HOLDING;
      3'd2:    byte_cur = reg_addr_i[15:8];
      3'd3:    byte_cur = reg_addr_i[7:0];
      3'd4:    byte_cur = REQ_COUNT_HI;
      3'd5:    byte_cur = REQ_COUNT_LO;
      3'd6:    byte_cur = crc_q[7:0];
      default: byte_cur = crc_q[15:8];
    endcase
  end

  assign push = act_q && ctrl_i.advance;

  always_comb begin
    act_d = act_q;
    idx_d = idx_q;
    crc_d = crc_q;
    if (ctrl_i.load) begin
      act_d = 1'b1;
      idx_d = '0;
      crc_d = CRC_INIT;
    end else if (push) begin
      // fold header bytes into the CRC; the two CRC bytes just leave
      if (idx_q < 3'd6) begin
        crc_d = crc_byte(crc_q, byte_cur);
      end
      idx_d = idx_q + 3'd1;
      if (idx_q == 3'd7) begin
        act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      idx_q <= '0;
    end else begin
      act_q <= act_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  assign stat_o.active  = act_q;
  assign stat_o.tx_byte = byte_cur;
  assign stat_o.last    = (idx_q == 3'd7);

endmodule

`default_nettype wire
